/* hw/rtl/ncdf_pkg.sv */
package ncdf_pkg;

  // item fields
  localparam int Z_W    = 16;
  localparam int MODE_W = 2;
  localparam int PROB_W = 16;

  // internal formats
  localparam int A_W       = 15;               // |z| Q.12 after the clamp
  localparam int SLOPE_W   = 14;
  localparam int D_W       = 30;               // denominator Q.28
  localparam int X_SHIFT   = 5;
  localparam int X_W       = 2 * A_W + X_SHIFT; // exponent z*z/2 in Q.30
  localparam int T_W       = 31;               // reciprocal t Q.30, up to one
  localparam int Q30_W     = 31;               // unsigned Q.30 values up to one
  localparam int ONE_SHIFT = 30;
  localparam int R_W       = 30;               // reduced argument, below ln2
  localparam int N_W       = 5;                // power of two taken out of exp
  localparam int M_W       = 30;               // series product before divide
  localparam int RECIP_W   = 32;
  localparam int RECIP_SHIFT = 31;
  localparam int P_W       = 33;               // signed Horner value
  localparam int PM_W      = 32;               // Horner magnitude
  localparam int INV_W     = 29;
  localparam int PHI_W     = 29;
  localparam int PROB_SHIFT = 14;

  localparam int RECIP_STAGES = T_W;
  localparam int NDIV_STAGES  = N_W;
  localparam int SERIES_TERMS = 12;
  localparam int HORNER_STEPS = 5;

  localparam logic [MODE_W-1:0] MODE_TWO_SIDED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_SIDED = 2'd1;

  localparam logic [A_W-1:0]   CLAMP_Q12      = 15'd24576;
  localparam logic [D_W-1:0]   D_BASE         = 30'h1000_0000;
  localparam logic [D_W-1:0]   RECIP_REM_INIT = 30'h0800_0000;
  localparam logic [Q30_W-1:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [Q30_W:0]   ROUND_HALF     = 32'h0000_2000;

  localparam logic [63:0] NANO = 64'd1000000000;
  localparam logic [63:0] SLOPE_Q16_W   = ((64'd231641900 << 16) + NANO / 2) / NANO;
  localparam logic [63:0] COEF1_Q30     = ((64'd319381530 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] COEF2_Q30     = ((64'd356563782 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] COEF3_Q30     = ((64'd1781477937 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] COEF4_Q30     = ((64'd1821255978 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] COEF5_Q30     = ((64'd1330274429 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] LN2_Q30       = ((64'd693147181 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] INV_SQRT2PI_W = ((64'd398942280 << 30) + NANO / 2) / NANO;
  localparam logic [63:0] RECIP_ONE     = 64'd1 << RECIP_SHIFT;

  localparam logic [SLOPE_W-1:0] SLOPE_Q16       = SLOPE_W'(SLOPE_Q16_W);
  localparam logic [INV_W-1:0]   INV_SQRT2PI_Q30 = INV_W'(INV_SQRT2PI_W);

  localparam logic signed [P_W-1:0] HORNER_LEAD = P_W'(COEF5_Q30);
  localparam logic signed [P_W-1:0] HORNER_ADD [0:HORNER_STEPS-1] = '{
    -P_W'(COEF4_Q30),
    P_W'(COEF3_Q30),
    -P_W'(COEF2_Q30),
    P_W'(COEF1_Q30),
    P_W'(0)
  };

  // floor(2^31 / k) for k = 12 down to 1
  localparam logic [RECIP_W-1:0] RECIP_TAB [0:SERIES_TERMS-1] = '{
    RECIP_W'(RECIP_ONE / 64'd12),
    RECIP_W'(RECIP_ONE / 64'd11),
    RECIP_W'(RECIP_ONE / 64'd10),
    RECIP_W'(RECIP_ONE / 64'd9),
    RECIP_W'(RECIP_ONE / 64'd8),
    RECIP_W'(RECIP_ONE / 64'd7),
    RECIP_W'(RECIP_ONE / 64'd6),
    RECIP_W'(RECIP_ONE / 64'd5),
    RECIP_W'(RECIP_ONE / 64'd4),
    RECIP_W'(RECIP_ONE / 64'd3),
    RECIP_W'(RECIP_ONE / 64'd2),
    RECIP_W'(RECIP_ONE / 64'd1)
  };

  typedef struct packed {
    logic signed [Z_W-1:0] z_value;
    logic [MODE_W-1:0]     mode;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              clamped;
  } out_item_t;

  typedef struct packed {
    logic              negative;
    logic              clamped;
    logic [MODE_W-1:0] mode;
  } side_t;

  typedef struct packed {
    logic [D_W-1:0] d;
    logic [X_W-1:0] x;
    side_t          side;
  } front_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    side_t          side;
  } exp_tag_t;

endpackage

/* hw/rtl/ncdf_front.sv */
module ncdf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ncdf_pkg::in_item_t in_item,
  output logic               front_valid,
  output ncdf_pkg::front_t   front_data
);
  import ncdf_pkg::*;

  logic [Z_W-1:0]     mag_nxt;
  logic               clamp_nxt;
  logic [A_W-1:0]     a_nxt;
  logic [A_W-1:0]     a_r;
  side_t              side_r;
  logic               s1_vld_r;
  logic               s2_vld_r;
  logic [2*A_W-1:0]   sq_nxt;
  front_t             front_r;

  always_comb begin
    mag_nxt   = in_item.z_value[Z_W-1] ? Z_W'(-in_item.z_value) : Z_W'(in_item.z_value);
    clamp_nxt = mag_nxt > Z_W'(CLAMP_Q12);
    a_nxt     = clamp_nxt ? CLAMP_Q12 : mag_nxt[A_W-1:0];
    sq_nxt    = (2*A_W)'(a_r) * (2*A_W)'(a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r             <= a_nxt;
      side_r.negative <= in_item.z_value[Z_W-1];
      side_r.clamped  <= clamp_nxt;
      side_r.mode     <= in_item.mode;
      front_r.d       <= D_BASE + D_W'(SLOPE_Q16) * D_W'(a_r);
      front_r.x       <= {sq_nxt, {X_SHIFT{1'b0}}};
      front_r.side    <= side_r;
    end
  end

  assign front_valid = s2_vld_r;
  assign front_data  = front_r;

endmodule

/* hw/rtl/ncdf_recip.sv */
module ncdf_recip (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ncdf_pkg::D_W-1:0] d_i,
  output logic [ncdf_pkg::T_W-1:0] t_o
);
  import ncdf_pkg::*;

  localparam int LAST = RECIP_STAGES - 1;

  logic [D_W-1:0] rem_r [0:LAST-1];
  logic [D_W-1:0] div_r [0:LAST-1];
  logic [T_W-1:0] quo_r [0:LAST];

  // restoring division of 2^58 + d/2 by d, one quotient bit per stage
  for (genvar i = 0; i < RECIP_STAGES; i++) begin : g_stage
    localparam int B = T_W - 1 - i;

    logic [D_W-1:0] rem_in;
    logic [D_W-1:0] div_in;
    logic [T_W-1:0] quo_in;
    logic           nbit;
    logic [D_W:0]   trial_nxt;
    logic           take_nxt;

    if (i == 0) begin : g_first
      assign rem_in = RECIP_REM_INIT;
      assign div_in = d_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign div_in = div_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // low numerator bits are d/2
    if (B < D_W - 1) begin : g_low
      assign nbit = div_in[B+1];
    end else begin : g_high
      assign nbit = 1'b0;
    end

    assign trial_nxt = {rem_in, nbit};
    assign take_nxt  = trial_nxt >= {1'b0, div_in};

    always_ff @(posedge clk) begin
      if (en) quo_r[i] <= {quo_in[T_W-2:0], take_nxt};
    end

    if (i < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take_nxt ? D_W'(trial_nxt - {1'b0, div_in}) : trial_nxt[D_W-1:0];
          div_r[i] <= div_in;
        end
      end
    end
  end

  assign t_o = quo_r[LAST];

endmodule

/* hw/rtl/ncdf_poly.sv */
module ncdf_poly (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ncdf_pkg::T_W-1:0]  t_i,
  output logic [ncdf_pkg::PM_W-1:0] poly_o
);
  import ncdf_pkg::*;

  localparam int LAST = HORNER_STEPS - 1;
  localparam int PR_W = T_W + PM_W;

  logic [PR_W-1:0]         s1_prod_r [0:LAST];
  logic                    s1_neg_r  [0:LAST];
  logic [T_W-1:0]          s1_t_r    [0:LAST-1];
  logic signed [P_W-1:0]   s2_p_r    [0:LAST];
  logic [T_W-1:0]          s2_t_r    [0:LAST-1];
  logic [PM_W-1:0]         poly_r;

  // horner step: multiply magnitude, then truncate toward zero and add
  for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_step
    logic signed [P_W-1:0] p_in;
    logic [T_W-1:0]        t_in;
    logic [PM_W-1:0]       mag_nxt;
    logic [PM_W-1:0]       trunc_nxt;
    logic signed [P_W-1:0] term_nxt;

    if (h == 0) begin : g_first
      assign p_in = HORNER_LEAD;
      assign t_in = t_i;
    end else begin : g_next
      assign p_in = s2_p_r[h-1];
      assign t_in = s2_t_r[h-1];
    end

    assign mag_nxt   = p_in[P_W-1] ? PM_W'(-p_in) : PM_W'(p_in);
    assign trunc_nxt = s1_prod_r[h][ONE_SHIFT +: PM_W];
    assign term_nxt  = s1_neg_r[h] ? -$signed({1'b0, trunc_nxt}) : $signed({1'b0, trunc_nxt});

    always_ff @(posedge clk) begin
      if (en) begin
        s1_prod_r[h] <= PR_W'(t_in) * PR_W'(mag_nxt);
        s1_neg_r[h]  <= p_in[P_W-1];
        s2_p_r[h]    <= HORNER_ADD[h] + term_nxt;
      end
    end

    if (h < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          s1_t_r[h] <= t_in;
          s2_t_r[h] <= s1_t_r[h];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) poly_r <= s2_p_r[LAST][P_W-1] ? '0 : s2_p_r[LAST][PM_W-1:0];
  end

  assign poly_o = poly_r;

endmodule

/* hw/rtl/ncdf_exp.sv */
module ncdf_exp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ncdf_pkg::X_W-1:0]   x_i,
  input  ncdf_pkg::side_t            side_i,
  output logic                       out_valid,
  output logic [ncdf_pkg::Q30_W-1:0] ex_o,
  output ncdf_pkg::side_t            side_o
);
  import ncdf_pkg::*;

  localparam int ND_LAST = NDIV_STAGES - 1;
  localparam int S_LAST  = SERIES_TERMS - 1;
  localparam int AP_W    = R_W + Q30_W;
  localparam int BQ_W    = M_W + RECIP_W;

  logic [X_W-1:0]   nd_rem_r [0:ND_LAST];
  exp_tag_t         nd_tag_r [0:ND_LAST];
  logic             nd_vld_r [0:ND_LAST];

  logic [AP_W-1:0]  a_prod_r [0:S_LAST];
  logic [R_W-1:0]   a_r_r    [0:S_LAST-1];
  exp_tag_t         a_tag_r  [0:S_LAST];
  logic             a_vld_r  [0:S_LAST];

  logic [M_W-1:0]   b_m_r    [0:S_LAST];
  logic [BQ_W-1:0]  b_qe_r   [0:S_LAST];
  logic [R_W-1:0]   b_r_r    [0:S_LAST-1];
  exp_tag_t         b_tag_r  [0:S_LAST];
  logic             b_vld_r  [0:S_LAST];

  logic [Q30_W-1:0] c_e_r    [0:S_LAST];
  logic [R_W-1:0]   c_r_r    [0:S_LAST-1];
  exp_tag_t         c_tag_r  [0:S_LAST];
  logic             c_vld_r  [0:S_LAST];

  logic [Q30_W-1:0] ex_r;
  side_t            side_r;
  logic             vld_r;

  // x = n*ln2 + r, one bit of n per stage
  for (genvar j = 0; j < NDIV_STAGES; j++) begin : g_ndiv
    localparam int B = N_W - 1 - j;
    localparam logic [X_W-1:0] SUB = X_W'(LN2_Q30 << B);

    logic [X_W-1:0] rem_in;
    exp_tag_t       tag_in;
    logic           vld_in;
    logic           take_nxt;

    if (j == 0) begin : g_first
      assign rem_in      = x_i;
      assign tag_in.n    = '0;
      assign tag_in.side = side_i;
      assign vld_in      = in_valid;
    end else begin : g_next
      assign rem_in = nd_rem_r[j-1];
      assign tag_in = nd_tag_r[j-1];
      assign vld_in = nd_vld_r[j-1];
    end

    assign take_nxt = rem_in >= SUB;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nd_vld_r[j] <= 1'b0;
      end else if (en) begin
        nd_vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd_rem_r[j]      <= take_nxt ? rem_in - SUB : rem_in;
        nd_tag_r[j].n    <= {tag_in.n[N_W-2:0], take_nxt};
        nd_tag_r[j].side <= tag_in.side;
      end
    end
  end

  // e = 1 - r*e/k for k from twelve down to one: multiply, reciprocal, correct
  for (genvar s = 0; s < SERIES_TERMS; s++) begin : g_term
    localparam logic [M_W-1:0] K_M = M_W'(SERIES_TERMS - s);

    logic [Q30_W-1:0] e_in;
    logic [R_W-1:0]   r_in;
    exp_tag_t         tag_in;
    logic             vld_in;
    logic [M_W-1:0]   m_nxt;
    logic [M_W-1:0]   q0_nxt;
    logic [M_W-1:0]   back_nxt;
    logic [M_W-1:0]   rem_nxt;
    logic [M_W-1:0]   quo_nxt;

    if (s == 0) begin : g_first
      assign e_in   = Q30_ONE;
      assign r_in   = nd_rem_r[ND_LAST][R_W-1:0];
      assign tag_in = nd_tag_r[ND_LAST];
      assign vld_in = nd_vld_r[ND_LAST];
    end else begin : g_next
      assign e_in   = c_e_r[s-1];
      assign r_in   = c_r_r[s-1];
      assign tag_in = c_tag_r[s-1];
      assign vld_in = c_vld_r[s-1];
    end

    assign m_nxt    = a_prod_r[s][ONE_SHIFT +: M_W];
    assign q0_nxt   = b_qe_r[s][RECIP_SHIFT +: M_W];
    assign back_nxt = q0_nxt * K_M;
    assign rem_nxt  = b_m_r[s] - back_nxt;
    // reciprocal estimate is low by at most one
    assign quo_nxt  = q0_nxt + M_W'(rem_nxt >= K_M);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[s] <= 1'b0;
        b_vld_r[s] <= 1'b0;
        c_vld_r[s] <= 1'b0;
      end else if (en) begin
        a_vld_r[s] <= vld_in;
        b_vld_r[s] <= a_vld_r[s];
        c_vld_r[s] <= b_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod_r[s] <= AP_W'(r_in) * AP_W'(e_in);
        a_tag_r[s]  <= tag_in;
        b_m_r[s]    <= m_nxt;
        b_qe_r[s]   <= BQ_W'(m_nxt) * BQ_W'(RECIP_TAB[s]);
        b_tag_r[s]  <= a_tag_r[s];
        c_e_r[s]    <= Q30_ONE - Q30_W'(quo_nxt);
        c_tag_r[s]  <= b_tag_r[s];
      end
    end

    if (s < S_LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          a_r_r[s] <= r_in;
          b_r_r[s] <= a_r_r[s];
          c_r_r[s] <= b_r_r[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= c_vld_r[S_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r   <= c_e_r[S_LAST] >> c_tag_r[S_LAST].n;
      side_r <= c_tag_r[S_LAST].side;
    end
  end

  assign out_valid = vld_r;
  assign ex_o      = ex_r;
  assign side_o    = side_r;

endmodule

/* hw/rtl/ncdf_tail.sv */
module ncdf_tail (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ncdf_pkg::Q30_W-1:0] ex_i,
  input  logic [ncdf_pkg::PM_W-1:0]  poly_i,
  input  ncdf_pkg::side_t            side_i,
  output logic                       out_valid,
  output ncdf_pkg::out_item_t        out_item
);
  import ncdf_pkg::*;

  localparam int PH_W = Q30_W + INV_W;
  localparam int QP_W = PHI_W + PM_W;
  localparam int RD_W = Q30_W + 1;
  localparam int O_W  = RD_W - PROB_SHIFT;

  logic [PH_W-1:0]   phi_prod_nxt;
  logic [QP_W-1:0]   q_prod_nxt;
  logic [Q30_W-1:0]  q_raw_nxt;
  logic [Q30_W:0]    two_q_nxt;
  logic [Q30_W-1:0]  v_nxt;
  logic [RD_W-1:0]   round_nxt;
  logic [O_W-1:0]    scaled_nxt;

  logic [PHI_W-1:0]  phi_r;
  logic [PM_W-1:0]   poly_r;
  side_t             side1_r;
  logic              vld1_r;
  logic [Q30_W-1:0]  q_r;
  side_t             side2_r;
  logic              vld2_r;
  out_item_t         out_r;
  logic              out_vld_r;

  always_comb begin
    phi_prod_nxt = PH_W'(ex_i) * PH_W'(INV_SQRT2PI_Q30);
    q_prod_nxt   = QP_W'(phi_r) * QP_W'(poly_r);
    q_raw_nxt    = q_prod_nxt[ONE_SHIFT +: Q30_W];
    two_q_nxt    = {q_r, 1'b0};
    case (side2_r.mode)
      MODE_TWO_SIDED: begin
        v_nxt = (two_q_nxt >= {1'b0, Q30_ONE}) ? '0 : Q30_W'({1'b0, Q30_ONE} - two_q_nxt);
      end
      MODE_ONE_SIDED: begin
        v_nxt = Q30_ONE - q_r;
      end
      default: begin
        v_nxt = side2_r.negative ? q_r : Q30_ONE - q_r;
      end
    endcase
    round_nxt  = {1'b0, v_nxt} + ROUND_HALF;
    scaled_nxt = round_nxt[RD_W-1:PROB_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld1_r    <= in_valid;
      vld2_r    <= vld1_r;
      out_vld_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r             <= phi_prod_nxt[ONE_SHIFT +: PHI_W];
      poly_r            <= poly_i;
      side1_r           <= side_i;
      q_r               <= (q_raw_nxt > Q30_ONE) ? Q30_ONE : q_raw_nxt;
      side2_r           <= side1_r;
      // one saturates to the largest code
      out_r.probability <= (scaled_nxt[O_W-1:PROB_W] != '0) ? '1 : scaled_nxt[PROB_W-1:0];
      out_r.clamped     <= side2_r.clamped;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

/* hw/rtl/normal_cdf_approximator_top.sv */
// Normal CDF by the five-term rational approximation, Q4.12 z in, Q0.16 probability out;
// the mode selects the two-sided or one-sided probability, or else the signed CDF of z.
// Fully pipelined: one transfer per cycle on each side while the output is not stalled.
// The 31-stage reciprocal divider is followed by the Horner polynomial, which runs
// alongside the range reduction and the twelve-term exp series; both branches are 42
// stages and meet in the phi and tail product stages. A stalled output register freezes
// the whole pipeline, so input is held off only while a waiting result is not taken.
module normal_cdf_approximator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ncdf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ncdf_pkg::out_item_t out_item
);
  import ncdf_pkg::*;

  logic             en;
  logic             front_valid;
  front_t           front_data;
  logic [T_W-1:0]   t_val;
  logic [PM_W-1:0]  poly_val;
  logic             exp_valid;
  logic [Q30_W-1:0] ex_val;
  side_t            exp_side;

  // pipeline moves unless a finished result is held by the receiver
  assign en       = ~out_valid | ~out_stall;
  assign in_stall = ~en;

  ncdf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .front_valid (front_valid),
    .front_data  (front_data)
  );

  ncdf_recip u_recip (
    .clk (clk),
    .en  (en),
    .d_i (front_data.d),
    .t_o (t_val)
  );

  ncdf_poly u_poly (
    .clk    (clk),
    .en     (en),
    .t_i    (t_val),
    .poly_o (poly_val)
  );

  ncdf_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .x_i       (front_data.x),
    .side_i    (front_data.side),
    .out_valid (exp_valid),
    .ex_o      (ex_val),
    .side_o    (exp_side)
  );

  ncdf_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (exp_valid),
    .ex_i      (ex_val),
    .poly_i    (poly_val),
    .side_i    (exp_side),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
